FILE: rtl/core/rtat_pkg.sv
// shared types and constants of the range table address translator
`default_nettype none

package rtat_pkg;

  // table depth default
  localparam int MAX_ENTRIES_DEF = 16;

  // field widths
  localparam int IDX_W    = 4;
  localparam int ADDR_W   = 32;
  localparam int PAGES_W  = 21;
  localparam int FRAME_W  = 32;
  localparam int PS_W     = 17;
  localparam int NUSE_W   = 5;
  localparam int PHYS_W   = 64;
  localparam int LEN_W    = PAGES_W + PS_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = PS_W;

  // word kinds
  localparam logic KIND_TRANSLATE = 1'b0;
  localparam logic KIND_WRITE     = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_USE = 2'd1;

  localparam logic [PS_W-1:0] PAGE_SIZE_RST = 17'd8192;

  // word travelling down the cell chain
  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [IDX_W-1:0]   idx;
    logic [ADDR_W-1:0]  base;
    logic [PAGES_W-1:0] pages;
    logic [FRAME_W-1:0] frame;
    logic [ADDR_W-1:0]  va;
    logic               found;
    logic [FRAME_W-1:0] sel_frame;
    logic [ADDR_W-1:0]  sel_off;
  } token_t;

endpackage

`default_nettype wire

FILE: rtl/core/rtat_cell.sv
// one table entry of the chain: stores its range and checks passing words against it
`default_nettype none

module rtat_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        en,
  input  wire [rtat_pkg::PS_W-1:0]   page_size,
  input  wire [rtat_pkg::NUSE_W-1:0] entries_in_use,
  input  wire rtat_pkg::token_t      tok_in,
  output rtat_pkg::token_t           tok_out
);

  logic [rtat_pkg::ADDR_W-1:0]  base_r;
  logic [rtat_pkg::PAGES_W-1:0] pages_r;
  logic [rtat_pkg::FRAME_W-1:0] frame_r;

  rtat_pkg::token_t tok_r;
  rtat_pkg::token_t tok_nxt;

  logic                        wr_hit;
  logic                        searched;
  logic [rtat_pkg::ADDR_W-1:0] off;
  logic [rtat_pkg::LEN_W-1:0]  len;
  logic                        match;

  // write addressed to this slot
  assign wr_hit = tok_in.valid && (tok_in.kind == rtat_pkg::KIND_WRITE) &&
                  (32'(tok_in.idx) == CELL_IDX);

  // range check, end kept at full width so it never wraps
  assign searched = (32'(entries_in_use) > CELL_IDX);
  assign off      = tok_in.va - base_r;
  assign len      = rtat_pkg::LEN_W'(pages_r) * rtat_pkg::LEN_W'(page_size);
  assign match    = tok_in.valid && (tok_in.kind == rtat_pkg::KIND_TRANSLATE) &&
                    !tok_in.found && searched && (tok_in.va >= base_r) &&
                    (rtat_pkg::LEN_W'(off) < len);

  // pass the word on, claiming it on the first match
  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.sel_frame = frame_r;
      tok_nxt.sel_off   = off;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (en && wr_hit) begin
      base_r  <= tok_in.base;
      pages_r <= tok_in.pages;
      frame_r <= tok_in.frame;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (en) begin
      tok_r.valid <= tok_nxt.valid;
    end
    if (en) begin
      tok_r.kind      <= tok_nxt.kind;
      tok_r.idx       <= tok_nxt.idx;
      tok_r.base      <= tok_nxt.base;
      tok_r.pages     <= tok_nxt.pages;
      tok_r.frame     <= tok_nxt.frame;
      tok_r.va        <= tok_nxt.va;
      tok_r.found     <= tok_nxt.found;
      tok_r.sel_frame <= tok_nxt.sel_frame;
      tok_r.sel_off   <= tok_nxt.sel_off;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

FILE: rtl/core/range_table_address_translator_top.sv
// top level of the range table address translator: cell chain, config and output stage
`default_nettype none

// Translates a 32-bit virtual address through a table of up to MAX_ENTRIES
// ranges, one range per cell of a chain. Every word (translate or entry
// write) walks the chain one cell per cycle while no result is held by
// out_stall, so writes and lookups keep their order and each cell sees them
// in sequence; the lowest matching cell claims a lookup. After the last cell,
// frame*page_size + offset is formed in the output register. One word is
// accepted per cycle unless a result is held in the output register by
// out_stall. A lookup passes MAX_ENTRIES + 1 registers (the cells and the
// output register), the first loaded at the accepting edge. Entry writes
// give no result. A miss returns all ones with hit low.
// Configuration is always ready (index 0 page size, index 1 entries in use)
// and must only be written while no word is in flight.
module range_table_address_translator_top #(
  parameter int MAX_ENTRIES = rtat_pkg::MAX_ENTRIES_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // input words
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             in_kind,
  input  wire [rtat_pkg::IDX_W-1:0]       in_entry_index,
  input  wire [rtat_pkg::ADDR_W-1:0]      in_entry_base,
  input  wire [rtat_pkg::PAGES_W-1:0]     in_entry_pages,
  input  wire [rtat_pkg::FRAME_W-1:0]     in_entry_frame,
  input  wire [rtat_pkg::ADDR_W-1:0]      in_virt_addr,
  // result words
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [rtat_pkg::PHYS_W-1:0]     out_phys_offset,
  output logic                            out_hit,
  // configuration writes
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [rtat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [rtat_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [rtat_pkg::PS_W-1:0]   page_size_r;
  logic [rtat_pkg::NUSE_W-1:0] entries_use_r;

  logic                        en;
  rtat_pkg::token_t            chain [MAX_ENTRIES+1];
  rtat_pkg::token_t            tail;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [rtat_pkg::PHYS_W-1:0] phys_r;
  logic [rtat_pkg::PHYS_W-1:0] phys_nxt;
  logic                        hit_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r   <= rtat_pkg::PAGE_SIZE_RST;
      entries_use_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rtat_pkg::REG_PAGE_SIZE) begin
        page_size_r <= cfg_wdata;
      end else if (cfg_index == rtat_pkg::REG_ENTRIES_USE) begin
        entries_use_r <= cfg_wdata[rtat_pkg::NUSE_W-1:0];
      end
    end
  end

  // whole chain advances unless a result is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // word entering the chain
  always_comb begin
    chain[0].valid     = in_valid;
    chain[0].kind      = in_kind;
    chain[0].idx       = in_entry_index;
    chain[0].base      = in_entry_base;
    chain[0].pages     = in_entry_pages;
    chain[0].frame     = in_entry_frame;
    chain[0].va        = in_virt_addr;
    chain[0].found     = 1'b0;
    chain[0].sel_frame = '0;
    chain[0].sel_off   = '0;
  end

  // row of cells
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    rtat_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .en            (en),
      .page_size     (page_size_r),
      .entries_in_use(entries_use_r),
      .tok_in        (chain[g]),
      .tok_out       (chain[g+1])
    );
  end

  assign tail = chain[MAX_ENTRIES];

  // final scaling of the claimed frame
  assign out_valid_nxt = tail.valid && (tail.kind == rtat_pkg::KIND_TRANSLATE);
  assign phys_nxt = tail.found ?
                    (rtat_pkg::PHYS_W'(tail.sel_frame) * rtat_pkg::PHYS_W'(page_size_r) +
                     rtat_pkg::PHYS_W'(tail.sel_off)) :
                    '1;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phys_r <= phys_nxt;
      hit_r  <= tail.found;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_phys_offset = phys_r;
  assign out_hit         = hit_r;

`ifndef SYNTHESIS
  // input only held back by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // a miss reads as all ones
  a_miss_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_phys_offset == '1))
    else $error("miss result not all ones");

  // write words never reach the output
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (en && tail.valid && (tail.kind == rtat_pkg::KIND_WRITE)) |=> !out_valid)
    else $error("entry write produced a result");
`endif

endmodule

`default_nettype wire

FILE: test/range_table_address_translator_top_test.sv
// testbench of the range table address translator: directed and random words, self-checking
`timescale 1ns / 100ps

module range_table_address_translator_top_test;
  import rtat_pkg::*;

  localparam int NUM_ENTRIES    = MAX_ENTRIES_DEF;
  localparam int FLUSH_CYCLES   = NUM_ENTRIES + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 140;

  typedef struct packed {
    logic [PHYS_W-1:0] phys;
    logic              hit;
  } xlat_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kind;
  logic [IDX_W-1:0]      in_entry_index;
  logic [ADDR_W-1:0]     in_entry_base;
  logic [PAGES_W-1:0]    in_entry_pages;
  logic [FRAME_W-1:0]    in_entry_frame;
  logic [ADDR_W-1:0]     in_virt_addr;
  logic                  out_valid;
  logic                  out_stall;
  logic [PHYS_W-1:0]     out_phys_offset;
  logic                  out_hit;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // shadow copy of the range table and registers
  logic [ADDR_W-1:0]  tbl_base  [NUM_ENTRIES];
  logic [PAGES_W-1:0] tbl_pages [NUM_ENTRIES];
  logic [FRAME_W-1:0] tbl_frame [NUM_ENTRIES];
  logic [PS_W-1:0]    cur_page_size;
  logic [NUSE_W-1:0]  cur_entries;

  xlat_result_t expected_xlats [$];
  int           error_count;
  bit           steady_send;

  range_table_address_translator_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_entry_index  (in_entry_index),
    .in_entry_base   (in_entry_base),
    .in_entry_pages  (in_entry_pages),
    .in_entry_frame  (in_entry_frame),
    .in_virt_addr    (in_virt_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_phys_offset (out_phys_offset),
    .out_hit         (out_hit),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected translation of one address; lowest matching entry wins
  function automatic xlat_result_t translate_va(input logic [ADDR_W-1:0] va);
    xlat_result_t res;
    logic [63:0]  lo;
    logic [63:0]  hi;
    int           n;
    res.phys = '1;
    res.hit  = 1'b0;
    n = (cur_entries > NUM_ENTRIES) ? NUM_ENTRIES : cur_entries;
    for (int i = n - 1; i >= 0; i--) begin
      lo = 64'(tbl_base[i]);
      hi = lo + 64'(tbl_pages[i]) * 64'(cur_page_size);
      if (lo <= 64'(va) && 64'(va) < hi) begin
        res.phys = 64'(tbl_frame[i]) * 64'(cur_page_size) + (64'(va) - lo);
        res.hit  = 1'b1;
      end
    end
    return res;
  endfunction

  // sender gap: mostly back to back, a few long pauses
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // address aimed at a searched entry: inside, just outside, or anywhere
  function automatic logic [ADDR_W-1:0] pick_va();
    int                n;
    int                k;
    logic [63:0]       span;
    logic [ADDR_W-1:0] b;
    n = (cur_entries > NUM_ENTRIES) ? NUM_ENTRIES : cur_entries;
    if (n == 0 || $urandom_range(0, 9) == 0) return $urandom;
    k = $urandom_range(0, n - 1);
    b = tbl_base[k];
    span = 64'(tbl_pages[k]) * 64'(cur_page_size);
    case ($urandom_range(0, 8))
      0: return b - 1;
      1: return b + span[31:0];
      2: return b + span[31:0] - 1;
      default: return (span == 0) ? b : b + 32'({$urandom, $urandom} % span);
    endcase
  endfunction

  // send one word and record what it should produce
  task automatic issue_word(input logic kind, input logic [IDX_W-1:0] idx,
                            input logic [ADDR_W-1:0] base, input logic [PAGES_W-1:0] pages,
                            input logic [FRAME_W-1:0] frame, input logic [ADDR_W-1:0] va);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= idx;
    in_entry_base  <= base;
    in_entry_pages <= pages;
    in_entry_frame <= frame;
    in_virt_addr   <= va;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_WRITE) begin
      tbl_base[idx]  = base;
      tbl_pages[idx] = pages;
      tbl_frame[idx] = frame;
    end else begin
      expected_xlats.push_back(translate_va(va));
    end
  endtask

  task automatic lookup(input logic [ADDR_W-1:0] va);
    issue_word(KIND_TRANSLATE, IDX_W'($urandom), $urandom, PAGES_W'($urandom), $urandom, va);
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] base,
                             input logic [PAGES_W-1:0] pages, input logic [FRAME_W-1:0] frame);
    issue_word(KIND_WRITE, idx, base, pages, frame, $urandom);
  endtask

  // random range: low, high or anywhere in the space, short to huge lengths
  task automatic write_random_entry(input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0]  b;
    logic [PAGES_W-1:0] p;
    logic [FRAME_W-1:0] f;
    case ($urandom_range(0, 3))
      0: b = $urandom_range(0, 32'h0010_0000);
      1: b = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
      default: b = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: p = '0;
      1: p = '1;
      2: p = PAGES_W'($urandom);
      3: p = PAGES_W'($urandom_range(1, 256));
      default: p = PAGES_W'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 3))
      0: f = '1;
      1: f = $urandom_range(0, 255);
      default: f = $urandom;
    endcase
    write_entry(idx, b, p, f);
  endtask

  // drop valid, wait for every result, then let write words drain the chain
  task automatic settle_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_xlats.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PAGE_SIZE) cur_page_size = data[PS_W-1:0];
    else if (idx == REG_ENTRIES_USE) cur_entries = data[NUSE_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits of the count register carry noise
  task automatic set_config(input logic [PS_W-1:0] ps, input logic [NUSE_W-1:0] nuse);
    logic [CFG_DATA_W-1:0] d;
    settle_pipeline();
    cfg_write(REG_PAGE_SIZE, ps);
    d = CFG_DATA_W'($urandom);
    d[NUSE_W-1:0] = nuse;
    cfg_write(REG_ENTRIES_USE, d);
  endtask

  // no entries searched after reset: everything misses
  task automatic test_empty_table();
    lookup('0);
    lookup('1);
  endtask

  // zero-length range, priority of overlapping ranges, range past the 32-bit top
  task automatic test_directed_ranges();
    write_entry(4'd0, 32'h0000_4000, '0, 32'd5);
    write_entry(4'd1, 32'h0001_0000, 21'd3, '1);
    write_entry(4'd2, 32'h0001_2000, 21'd4, 32'd7);
    write_entry(4'd3, 32'hFFFF_F000, '1, '0);
    set_config(PAGE_SIZE_RST, 5'd4);
    lookup(32'h0000_4000);
    lookup(32'h0001_0000);
    lookup(32'h0001_5FFF);
    lookup(32'h0001_6000);
    lookup(32'h0001_9FFF);
    lookup(32'h0001_A000);
    lookup(32'hFFFF_FFFF);
    lookup(32'hFFFF_EFFF);
  endtask

  // zero page size, page size above the nominal max, one-byte pages
  task automatic test_page_size_extremes();
    set_config('0, 5'd4);
    lookup(32'h0001_0000);
    set_config('1, 5'd4);
    lookup(32'h0003_0000);
    set_config(17'd1, 5'd4);
    lookup(32'h0001_0002);
    lookup(32'h0001_0003);
  endtask

  // every slot written before larger search counts are used
  task automatic test_fill_table();
    for (int i = 0; i < NUM_ENTRIES; i++) write_random_entry(IDX_W'(i));
  endtask

  task automatic test_random_phase(input logic [PS_W-1:0] ps, input logic [NUSE_W-1:0] nuse,
                                   input bit steady);
    set_config(ps, nuse);
    steady_send = steady;
    repeat (PHASE_WORDS) begin
      if ($urandom_range(0, 99) < 15) write_random_entry(IDX_W'($urandom_range(0, 15)));
      else lookup(pick_va());
    end
    steady_send = 1'b0;
  endtask

  // result stall: free stretches, short stalls and a few long ones
  initial begin
    int unsigned r;
    int unsigned len;
    logic        level;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        level = 1'b0;
        len = $urandom_range(20, 120);
      end else if (r < 70) begin
        level = 1'b0;
        len = $urandom_range(1, 6);
      end else if (r < 95) begin
        level = 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        level = 1'b1;
        len = $urandom_range(20, 60);
      end
      repeat (len) begin
        @(negedge clk);
        out_stall <= level;
      end
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    xlat_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_xlats.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word, expected none, got phys_offset %h hit %b",
                 $time, out_phys_offset, out_hit);
      end else begin
        exp_r = expected_xlats.pop_front();
        if (out_hit !== exp_r.hit) begin
          error_count++;
          $display("%0t: hit mismatch, expected %b, got %b", $time, exp_r.hit, out_hit);
        end
        if (out_phys_offset !== exp_r.phys) begin
          error_count++;
          $display("%0t: phys_offset mismatch, expected %h, got %h",
                   $time, exp_r.phys, out_phys_offset);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // main sequence
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_TRANSLATE;
    in_entry_index = '0;
    in_entry_base  = '0;
    in_entry_pages = '0;
    in_entry_frame = '0;
    in_virt_addr   = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_PAGE_SIZE;
    cfg_wdata      = '0;
    cur_page_size  = PAGE_SIZE_RST;
    cur_entries    = '0;
    error_count    = 0;
    steady_send    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_directed_ranges();
    test_page_size_extremes();
    test_fill_table();
    test_random_phase(PAGE_SIZE_RST, 5'd16, 1'b0);
    test_random_phase(17'd4096, 5'd31, 1'b1);
    test_random_phase(17'd1, 5'd17, 1'b0);
    test_random_phase(17'd65536, 5'd8, 1'b0);
    test_random_phase('1, 5'd1, 1'b1);
    test_random_phase('0, 5'd16, 1'b0);
    test_random_phase(PS_W'($urandom), 5'd0, 1'b0);
    repeat (3) test_random_phase(PS_W'($urandom), NUSE_W'($urandom), 1'b0);
    settle_pipeline();

    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: range_table_address_translator_top.f
rtl/core/rtat_pkg.sv
rtl/core/rtat_cell.sv
rtl/core/range_table_address_translator_top.sv
test/range_table_address_translator_top_test.sv
